// File: sv/spfc_pkg.sv
// Shared types and constants for the sphere position pipeline.
package spfc_pkg;

	typedef enum logic [1:0] {
		REG_FOCAL_LENGTH = 2'd0,
		REG_BALL_RADIUS  = 2'd1,
		REG_OPT_CENTER_X = 2'd2,
		REG_OPT_CENTER_Y = 2'd3
	} cfg_idx_t;

	localparam logic [15:0] FOCAL_RST  = 16'd8640;
	localparam logic [15:0] RADIUS_RST = 16'd512;
	localparam logic [13:0] OCX_RST    = 14'd5120;
	localparam logic [13:0] OCY_RST    = 14'd3840;

	localparam logic [23:0] POS_MAX = 24'h7FFFFF;
	localparam logic [23:0] NEG_MAX = 24'h800000;
	localparam logic [22:0] Z_MAX   = 23'h7FFFFF;
	localparam logic [48:0] ZQ_CAP  = 49'h1_0000_0000_0000;

	typedef struct packed {
		logic [13:0] center_x;
		logic [13:0] center_y;
		logic [11:0] circle_radius;
	} item_t;

	typedef struct packed {
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic [22:0]        pos_z;
		logic               on_axis;
		logic               saturated;
	} result_t;

	// Context that travels down the pipeline; fields fill in as stages finish.
	typedef struct packed {
		logic [13:0] ax;
		logic [13:0] ay;
		logic        nx;
		logic        ny;
		logic        on_axis;
		logic        degen;
		logic [11:0] r;
		logic [28:0] s2;
		logic [32:0] n;
		logic [27:0] rf;
		logic [22:0] l;
		logic [24:0] sn;
		logic [31:0] u;
		logic [31:0] v;
		logic [31:0] w;
		logic [59:0] q;
		logic [48:0] zq;
		logic [22:0] z;
		logic        sat_z;
		logic [63:0] numy;
		logic        ovfx;
		logic        ovfy;
		logic [23:0] xm;
	} ctx_t;

endpackage

// File: sv/sphere_position_from_circle_core.sv
// Top level: sphere position from one detected circle, fully pipelined.
//
//   channel   direction  handshake                  payload
//   item      in         item_valid / item_stall    spfc_pkg::item_t
//   result    out        result_valid / result_stall spfc_pkg::result_t
//   cfg       in         cfg_we                     cfg_index, cfg_data
//
// One transaction is taken per cycle while item_stall is low; a result passes through
// 264 register stages, most of them in the chain of bit-per-stage square roots and
// dividers.
// Reset clears all valid bits and loads the register defaults.
// A stalled result is held in the output register, one more lands in a skid
// register, and the whole pipeline freezes while the skid register is full.
module sphere_position_from_circle_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  spfc_pkg::item_t     item,
	output logic                result_valid,
	input  logic                result_stall,
	output spfc_pkg::result_t   result,
	input  logic                cfg_we,
	input  spfc_pkg::cfg_idx_t  cfg_index,
	input  logic [15:0]         cfg_data
);
	import spfc_pkg::*;

	localparam int TW = $bits(ctx_t);

	logic [15:0] focal_q, radius_q;
	logic [13:0] ocx_q, ocy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_q  <= FOCAL_RST;
			radius_q <= RADIUS_RST;
			ocx_q    <= OCX_RST;
			ocy_q    <= OCY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FOCAL_LENGTH: focal_q  <= cfg_data;
				REG_BALL_RADIUS:  radius_q <= cfg_data;
				REG_OPT_CENTER_X: ocx_q    <= cfg_data[13:0];
				REG_OPT_CENTER_Y: ocy_q    <= cfg_data[13:0];
			endcase
		end
	end

	logic en;
	logic skid_v_q, result_v_q;
	assign en = !skid_v_q;
	assign item_stall = skid_v_q;

	// Stage 1: offsets from the optical center.
	logic signed [14:0] dx, dy;
	ctx_t c0;
	always_comb begin
		dx = $signed({1'b0, item.center_x}) - $signed({1'b0, ocx_q});
		dy = $signed({1'b0, ocy_q}) - $signed({1'b0, item.center_y});
		c0 = '0;
		c0.nx = dx[14];
		c0.ny = dy[14];
		c0.ax = dx[14] ? 14'(-dx) : dx[13:0];
		c0.ay = dy[14] ? 14'(-dy) : dy[13:0];
		c0.on_axis = (dx == '0) && (dy == '0);
		c0.r = item.circle_radius;
		c0.degen = (item.circle_radius == '0) || (focal_q == '0);
	end

	logic v_s1, v_s2, v_s3;
	ctx_t c_s1, c_s2, c_s3;
	ctx_t c_s2_d, c_s3_d;
	logic [27:0] sqx_s2, sqy_s2;
	logic [31:0] ff_s2;

	always_comb begin
		c_s2_d = c_s1;
		c_s2_d.rf = 28'(c_s1.r) * 28'(focal_q);
		c_s3_d = c_s2;
		c_s3_d.s2 = 29'(sqx_s2) + 29'(sqy_s2);
		c_s3_d.n = 33'(sqx_s2) + 33'(sqy_s2) + 33'(ff_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1 <= c0;
			sqx_s2 <= 28'(c_s1.ax) * 28'(c_s1.ax);
			sqy_s2 <= 28'(c_s1.ay) * 28'(c_s1.ay);
			ff_s2 <= 32'(focal_q) * 32'(focal_q);
			c_s2 <= c_s2_d;
			c_s3 <= c_s3_d;
		end
	end

	// l = isqrt(s2 * 2^16), then sn = isqrt(n * 2^16).
	logic          l_valid, sn_valid;
	logic [22:0]   l_root;
	logic [24:0]   sn_root;
	logic [TW-1:0] l_tag, sn_tag;
	ctx_t          c_l, c_sn;

	spfc_sqrt #(.IW(45), .TW(TW)) u_sqrt_l (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s3), .in_val({c_s3.s2, 16'b0}), .in_tag(c_s3),
		.out_valid(l_valid), .out_root(l_root), .out_tag(l_tag)
	);

	always_comb begin
		c_l = ctx_t'(l_tag);
		c_l.l = l_root;
	end

	spfc_sqrt #(.IW(49), .TW(TW)) u_sqrt_sn (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(l_valid), .in_val({c_l.n, 16'b0}), .in_tag(c_l),
		.out_valid(sn_valid), .out_root(sn_root), .out_tag(sn_tag)
	);

	always_comb begin
		c_sn = ctx_t'(sn_tag);
		c_sn.sn = sn_root;
	end

	logic        v_s4;
	ctx_t        c_s4;
	logic [34:0] lr_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= sn_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s4 <= c_sn;
			lr_s4 <= 35'(c_sn.l) * 35'(c_sn.r);
		end
	end

	// u = 2^20 + round(l*r*2^12 / n), v = round(r*f*2^20 / n).
	logic          u_valid, v_valid;
	logic [31:0]   u_quo, v_quo;
	logic [TW-1:0] u_tag, v_tag;
	ctx_t          c_u, c_v;

	spfc_div #(.NW(48), .DW(33), .QW(32), .TW(TW)) u_div_u (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s4), .in_num({1'b0, lr_s4, 12'b0} + 48'(c_s4.n[32:1])),
		.in_den(c_s4.n), .in_tag(c_s4),
		.out_valid(u_valid), .out_quo(u_quo), .out_tag(u_tag)
	);

	always_comb begin
		c_u = ctx_t'(u_tag);
		c_u.u = u_quo + 32'h0010_0000;
	end

	spfc_div #(.NW(49), .DW(33), .QW(32), .TW(TW)) u_div_v (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(u_valid), .in_num({1'b0, c_u.rf, 20'b0} + 49'(c_u.n[32:1])),
		.in_den(c_u.n), .in_tag(c_u),
		.out_valid(v_valid), .out_quo(v_quo), .out_tag(v_tag)
	);

	always_comb begin
		c_v = ctx_t'(v_tag);
		c_v.v = v_quo;
	end

	logic        v_s6, v_s7;
	ctx_t        c_s6, c_s7;
	logic [63:0] uu_s6, vv_s6, ww_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_valid;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s6 <= c_v;
			uu_s6 <= 64'(c_v.u) * 64'(c_v.u);
			vv_s6 <= 64'(c_v.v) * 64'(c_v.v);
			c_s7 <= c_s6;
			ww_s7 <= uu_s6 + vv_s6;
		end
	end

	logic          w_valid;
	logic [31:0]   w_root;
	logic [TW-1:0] w_tag;
	ctx_t          c_w;

	spfc_sqrt #(.IW(64), .TW(TW)) u_sqrt_w (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s7), .in_val(ww_s7), .in_tag(c_s7),
		.out_valid(w_valid), .out_root(w_root), .out_tag(w_tag)
	);

	always_comb begin
		c_w = ctx_t'(w_tag);
		c_w.w = w_root;
	end

	logic        v_s8;
	ctx_t        c_s8;
	logic [47:0] rw_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= w_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s8 <= c_w;
			rw_s8 <= 48'(radius_q) * 48'(c_w.w);
		end
	end

	// q = round(R*w*2^12 / r) in Q32.
	logic          q_valid;
	logic [59:0]   q_quo;
	logic [TW-1:0] q_tag;
	ctx_t          c_q;

	spfc_div #(.NW(61), .DW(12), .QW(60), .TW(TW)) u_div_q (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s8), .in_num({1'b0, rw_s8, 12'b0} + 61'(c_s8.r[11:1])),
		.in_den(c_s8.r), .in_tag(c_s8),
		.out_valid(q_valid), .out_quo(q_quo), .out_tag(q_tag)
	);

	always_comb begin
		c_q = ctx_t'(q_tag);
		c_q.q = q_quo;
	end

	logic        v_s9, v_s10, v_s11, v_s12;
	ctx_t        c_s9, c_s10, c_s11, c_s12;
	ctx_t        c_s10_d, c_s11_d, c_s12_d;
	logic [52:0] ph_s9;
	logic [56:0] pl_s9;
	logic [62:0] px_s11, py_s11;
	logic [63:0] numx_s12;
	logic [53:0] zq_raw;
	logic [41:0] z_raw;
	logic [63:0] numx, numy;
	logic [47:0] den_lim;

	always_comb begin
		zq_raw = 54'(ph_s9) + 54'((58'(pl_s9) + 58'h0_0000_8000_0000) >> 32);
		z_raw = 42'((50'(c_s10.zq) + 50'd128) >> 8);
		numx = 64'(px_s11) + 64'({focal_q, 7'b0});
		numy = 64'(py_s11) + 64'({focal_q, 7'b0});
		den_lim = {focal_q, 8'b0, 24'b0};
		c_s10_d = c_s9;
		c_s10_d.zq = (zq_raw > 54'(ZQ_CAP)) ? ZQ_CAP : zq_raw[48:0];
		c_s11_d = c_s10;
		c_s11_d.z = (z_raw > 42'(Z_MAX)) ? Z_MAX : z_raw[22:0];
		c_s11_d.sat_z = z_raw > 42'(Z_MAX);
		c_s12_d = c_s11;
		c_s12_d.numy = numy;
		// A quotient of 2^24 or more clamps whatever its low bits are.
		c_s12_d.ovfx = numx >= 64'(den_lim);
		c_s12_d.ovfy = numy >= 64'(den_lim);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else if (en) begin
			v_s9 <= q_valid;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s9 <= c_q;
			ph_s9 <= 53'(c_q.q[59:32]) * 53'(c_q.sn);
			pl_s9 <= 57'(c_q.q[31:0]) * 57'(c_q.sn);
			c_s10 <= c_s10_d;
			c_s11 <= c_s11_d;
			px_s11 <= 63'(c_s10.zq) * 63'(c_s10.ax);
			py_s11 <= 63'(c_s10.zq) * 63'(c_s10.ay);
			c_s12 <= c_s12_d;
			numx_s12 <= numx;
		end
	end

	logic          x_valid, y_valid;
	logic [23:0]   x_quo, y_quo;
	logic [TW-1:0] x_tag, y_tag;
	ctx_t          c_x, c_y;

	spfc_div #(.NW(64), .DW(24), .QW(24), .TW(TW)) u_div_x (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s12), .in_num(c_s12.ovfx ? 64'd0 : numx_s12),
		.in_den({focal_q, 8'b0}), .in_tag(c_s12),
		.out_valid(x_valid), .out_quo(x_quo), .out_tag(x_tag)
	);

	always_comb begin
		c_x = ctx_t'(x_tag);
		c_x.xm = x_quo;
	end

	spfc_div #(.NW(64), .DW(24), .QW(24), .TW(TW)) u_div_y (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(x_valid), .in_num(c_x.ovfy ? 64'd0 : c_x.numy),
		.in_den({focal_q, 8'b0}), .in_tag(c_x),
		.out_valid(y_valid), .out_quo(y_quo), .out_tag(y_tag)
	);

	// Sign, clamping and the degenerate case.
	result_t     res_d;
	logic [23:0] magx, magy;
	logic        satx, saty;

	always_comb begin
		c_y = ctx_t'(y_tag);
		satx = 1'b0;
		saty = 1'b0;
		if (c_y.nx) begin
			if (c_y.ovfx || c_y.xm > NEG_MAX) begin
				magx = NEG_MAX;
				satx = 1'b1;
			end else begin
				magx = c_y.xm;
			end
		end else if (c_y.ovfx || c_y.xm > POS_MAX) begin
			magx = POS_MAX;
			satx = 1'b1;
		end else begin
			magx = c_y.xm;
		end
		if (c_y.ny) begin
			if (c_y.ovfy || y_quo > NEG_MAX) begin
				magy = NEG_MAX;
				saty = 1'b1;
			end else begin
				magy = y_quo;
			end
		end else if (c_y.ovfy || y_quo > POS_MAX) begin
			magy = POS_MAX;
			saty = 1'b1;
		end else begin
			magy = y_quo;
		end
		res_d.on_axis = c_y.on_axis;
		if (c_y.degen) begin
			res_d.pos_x = (c_y.ax == '0) ? '0 : (c_y.nx ? NEG_MAX : POS_MAX);
			res_d.pos_y = (c_y.ay == '0) ? '0 : (c_y.ny ? NEG_MAX : POS_MAX);
			res_d.pos_z = Z_MAX;
			res_d.saturated = 1'b1;
		end else begin
			res_d.pos_x = c_y.nx ? -magx : magx;
			res_d.pos_y = c_y.ny ? -magy : magy;
			res_d.pos_z = c_y.z;
			res_d.saturated = c_y.sat_z | satx | saty;
		end
	end

	result_t result_q, skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (result_v_q && result_stall) begin
			if (!skid_v_q && y_valid) begin
				skid_v_q <= 1'b1;
			end
		end else if (skid_v_q) begin
			result_v_q <= 1'b1;
			skid_v_q <= 1'b0;
		end else begin
			result_v_q <= y_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (result_v_q && result_stall) begin
			if (!skid_v_q) begin
				skid_q <= res_d;
			end
		end else if (skid_v_q) begin
			result_q <= skid_q;
		end else begin
			result_q <= res_d;
		end
	end

	assign result_valid = result_v_q;
	assign result = result_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> result_v_q)
		else $error("skid register full while output register is empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(result_v_q && result_stall))
		else $error("skid register filled while output was not held");

	a_on_axis_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.on_axis) |-> (result.pos_x == '0 && result.pos_y == '0))
		else $error("on-axis result with nonzero lateral position");

endmodule

// File: sv/spfc_sqrt.sv
// Pipelined integer square root, one result bit per stage, with a side tag.
module spfc_sqrt #(
	parameter int IW = 16,
	parameter int TW = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [IW-1:0]         in_val,
	input  logic [TW-1:0]         in_tag,
	output logic                  out_valid,
	output logic [(IW+1)/2-1:0]   out_root,
	output logic [TW-1:0]         out_tag
);
	localparam int RW = (IW + 1) / 2;
	localparam int CW = 2 * RW + 1;

	logic [RW-1:0] vld_s;
	logic [CW-1:0] rem_s  [RW];
	logic [RW-1:0] root_s [RW];
	logic [TW-1:0] tag_s  [RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		localparam int B = RW - 1 - k;
		logic          v_i;
		logic [CW-1:0] rem_i;
		logic [RW-1:0] root_i;
		logic [TW-1:0] tag_i;
		logic [CW-1:0] trial;
		logic          take;

		if (k == 0) begin : g_first
			assign v_i    = in_valid;
			assign rem_i  = CW'(in_val);
			assign root_i = '0;
			assign tag_i  = in_tag;
		end else begin : g_next
			assign v_i    = vld_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign root_i = root_s[k-1];
			assign tag_i  = tag_s[k-1];
		end

		// (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B)
		assign trial = (CW'(root_i) << (B + 1)) + (CW'(1) << (2 * B));
		assign take  = rem_i >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? rem_i - trial : rem_i;
				root_s[k] <= take ? (root_i | (RW'(1) << B)) : root_i;
				tag_s[k]  <= tag_i;
			end
		end
	end

	assign out_valid = vld_s[RW-1];
	assign out_root  = root_s[RW-1];
	assign out_tag   = tag_s[RW-1];

endmodule

// File: sv/spfc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
module spfc_div #(
	parameter int NW = 32,
	parameter int DW = 16,
	parameter int QW = 16,
	parameter int TW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] in_num,
	input  logic [DW-1:0] in_den,
	input  logic [TW-1:0] in_tag,
	output logic          out_valid,
	output logic [QW-1:0] out_quo,
	output logic [TW-1:0] out_tag
);
	localparam int CW = (NW > DW + QW) ? NW : DW + QW;

	logic [QW-1:0] vld_s;
	logic [CW-1:0] rem_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] quo_s [QW];
	logic [TW-1:0] tag_s [QW];

	// The caller guarantees the quotient fits in QW bits.
	for (genvar k = 0; k < QW; k++) begin : g_stage
		localparam int B = QW - 1 - k;
		logic          v_i;
		logic [CW-1:0] rem_i;
		logic [DW-1:0] den_i;
		logic [QW-1:0] quo_i;
		logic [TW-1:0] tag_i;
		logic [CW-1:0] trial;
		logic          take;

		if (k == 0) begin : g_first
			assign v_i   = in_valid;
			assign rem_i = CW'(in_num);
			assign den_i = in_den;
			assign quo_i = '0;
			assign tag_i = in_tag;
		end else begin : g_next
			assign v_i   = vld_s[k-1];
			assign rem_i = rem_s[k-1];
			assign den_i = den_s[k-1];
			assign quo_i = quo_s[k-1];
			assign tag_i = tag_s[k-1];
		end

		assign trial = CW'(den_i) << B;
		assign take  = rem_i >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= take ? rem_i - trial : rem_i;
				den_s[k] <= den_i;
				quo_s[k] <= take ? (quo_i | (QW'(1) << B)) : quo_i;
				tag_s[k] <= tag_i;
			end
		end
	end

	assign out_valid = vld_s[QW-1];
	assign out_quo   = quo_s[QW-1];
	assign out_tag   = tag_s[QW-1];

endmodule

// File: tb/tb_top.sv
// Testbench for the sphere position core: directed and random circles against a local predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import spfc_pkg::*;

	localparam int LATENCY = 264;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	item_t item;
	logic result_valid;
	logic result_stall;
	result_t result;
	logic cfg_we;
	cfg_idx_t cfg_index;
	logic [15:0] cfg_data;

	sphere_position_from_circle_core dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	logic [15:0] focal;
	logic [15:0] ball_r;
	logic [13:0] ocx;
	logic [13:0] ocy;

	result_t expected_positions[$];
	int errors = 0;
	bit hold_off = 0;
	bit quiet_rx = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("tb_top failed");
		$finish;
	end

	function automatic logic [63:0] int_sqrt(input logic [63:0] val);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > val) bitv >>= 2;
		while (bitv != 0) begin
			if (val >= res + bitv) begin
				val -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic logic [23:0] clamp24(input logic [63:0] mag, input bit neg,
			inout bit sat);
		if (neg) begin
			if (mag > 64'd8388608) begin
				mag = 64'd8388608;
				sat = 1;
			end
			return 24'(64'd0 - mag);
		end
		if (mag > 64'd8388607) begin
			mag = 64'd8388607;
			sat = 1;
		end
		return 24'(mag);
	endfunction

	function automatic result_t predict_position(input item_t it);
		result_t res;
		logic [63:0] ax, ay, s2, n, l, u, v, w, sn, q, zq, z, xm, ym, f, r, rb;
		bit nx, ny, sat;
		f = focal;
		rb = ball_r;
		r = it.circle_radius;
		nx = it.center_x < ocx;
		ny = ocy < it.center_y;
		ax = nx ? ocx - it.center_x : it.center_x - ocx;
		ay = ny ? it.center_y - ocy : ocy - it.center_y;
		sat = 0;
		res.on_axis = (ax == 0 && ay == 0);
		if (r == 0 || f == 0) begin
			sat = 1;
			res.pos_x = clamp24(ax != 0 ? 64'd8388609 : 64'd0, nx, sat);
			res.pos_y = clamp24(ay != 0 ? 64'd8388609 : 64'd0, ny, sat);
			res.pos_z = Z_MAX;
			res.saturated = 1;
			return res;
		end
		s2 = ax * ax + ay * ay;
		n = s2 + f * f;
		l = int_sqrt(s2 << 16);
		u = (64'd1 << 20) + (((l * r) << 12) + n / 2) / n;
		v = (((r * f) << 20) + n / 2) / n;
		w = int_sqrt(u * u + v * v);
		sn = int_sqrt(n << 16);
		q = (((rb * w) << 12) + r / 2) / r;
		zq = (q >> 32) * sn + (((q & 64'hFFFFFFFF) * sn + (64'd1 << 31)) >> 32);
		if (zq > (64'd1 << 48)) zq = 64'd1 << 48;
		z = (zq + 128) >> 8;
		if (z > 64'd8388607) begin
			z = 64'd8388607;
			sat = 1;
		end
		xm = (zq * ax + f * 128) / (f * 256);
		ym = (zq * ay + f * 128) / (f * 256);
		res.pos_x = clamp24(xm, nx, sat);
		res.pos_y = clamp24(ym, ny, sat);
		res.pos_z = z[22:0];
		res.saturated = sat;
		return res;
	endfunction

	// Receiver: stalls on its own pattern unless told to hold off or stay quiet.
	initial begin
		int pattern;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			pattern = $urandom_range(0, 7);
			if (hold_off) result_stall <= 1'b1;
			else if (quiet_rx) result_stall <= 1'b0;
			else result_stall <= (pattern < 3);
		end
	end

	always @(posedge clk) begin
		result_t exp_res;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_positions.size() == 0) begin
				$display("%0t unexpected result %h", $time, result);
				errors++;
			end else begin
				exp_res = expected_positions.pop_front();
				if (result.pos_x !== exp_res.pos_x) begin
					$display("%0t pos_x expected %0d actual %0d", $time,
						exp_res.pos_x, result.pos_x);
					errors++;
				end
				if (result.pos_y !== exp_res.pos_y) begin
					$display("%0t pos_y expected %0d actual %0d", $time,
						exp_res.pos_y, result.pos_y);
					errors++;
				end
				if (result.pos_z !== exp_res.pos_z) begin
					$display("%0t pos_z expected %0d actual %0d", $time,
						exp_res.pos_z, result.pos_z);
					errors++;
				end
				if (result.on_axis !== exp_res.on_axis) begin
					$display("%0t on_axis expected %0b actual %0b", $time, exp_res.on_axis,
						result.on_axis);
					errors++;
				end
				if (result.saturated !== exp_res.saturated) begin
					$display("%0t saturated expected %0b actual %0b", $time, exp_res.saturated,
						result.saturated);
					errors++;
				end
			end
		end
	end

	// Offers one circle and waits until the transaction is accepted.
	task automatic send_circle(input item_t it);
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		expected_positions.push_back(predict_position(it));
	endtask

	task automatic idle_cycles(input int count);
		item_valid <= 1'b0;
		repeat (count) @(posedge clk);
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		while (expected_positions.size() != 0) @(posedge clk);
	endtask

	task automatic write_register(input cfg_idx_t idx, input logic [15:0] val);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_FOCAL_LENGTH: focal = val;
			REG_BALL_RADIUS: ball_r = val;
			REG_OPT_CENTER_X: ocx = val[13:0];
			REG_OPT_CENTER_Y: ocy = val[13:0];
		endcase
	endtask

	function automatic item_t random_circle();
		item_t it;
		int mode;
		mode = $urandom_range(0, 9);
		it.center_x = 14'($urandom);
		it.center_y = 14'($urandom);
		it.circle_radius = 12'($urandom_range(80, 3840));
		if (mode == 0) it.circle_radius = 12'($urandom);
		else if (mode == 1) begin
			it.center_x = ocx;
			it.center_y = ocy;
		end else if (mode < 6) begin
			it.center_x = 14'(int'(ocx) + $urandom_range(0, 4000) - 2000);
			it.center_y = 14'(int'(ocy) + $urandom_range(0, 4000) - 2000);
		end
		return it;
	endfunction

	task automatic test_directed();
		send_circle('{center_x: 14'd0, center_y: 14'd0, circle_radius: 12'd80});
		send_circle('{center_x: 14'h3FFF, center_y: 14'h3FFF, circle_radius: 12'd3840});
		send_circle('{center_x: ocx, center_y: ocy, circle_radius: 12'd80});
		send_circle('{center_x: ocx, center_y: ocy, circle_radius: 12'hFFF});
		send_circle('{center_x: 14'h3FFF, center_y: 14'd0, circle_radius: 12'd0});
		send_circle('{center_x: ocx, center_y: ocy, circle_radius: 12'd0});
		send_circle('{center_x: ocx, center_y: 14'd0, circle_radius: 12'd1});
		send_circle('{center_x: 14'd0, center_y: ocy, circle_radius: 12'd1});
		send_circle('{center_x: ocx + 14'd1, center_y: ocy - 14'd1, circle_radius: 12'd1000});
		send_circle('{center_x: 14'h2AAA, center_y: 14'h1555, circle_radius: 12'hAAA});
		send_circle('{center_x: 14'h1555, center_y: 14'h2AAA, circle_radius: 12'h555});
	endtask

	task automatic test_register_extremes();
		write_register(REG_FOCAL_LENGTH, 16'd0);
		send_circle('{center_x: 14'd100, center_y: 14'd9000, circle_radius: 12'd500});
		send_circle('{center_x: ocx, center_y: ocy, circle_radius: 12'd500});
		write_register(REG_FOCAL_LENGTH, 16'd16);
		write_register(REG_BALL_RADIUS, 16'hFFFF);
		send_circle('{center_x: 14'd0, center_y: 14'h3FFF, circle_radius: 12'd80});
		send_circle('{center_x: ocx, center_y: ocy, circle_radius: 12'd1});
		write_register(REG_FOCAL_LENGTH, 16'hFFFF);
		write_register(REG_BALL_RADIUS, 16'd0);
		send_circle('{center_x: 14'd77, center_y: 14'd9999, circle_radius: 12'd300});
		write_register(REG_BALL_RADIUS, 16'd1);
		write_register(REG_OPT_CENTER_X, 16'd0);
		write_register(REG_OPT_CENTER_Y, 16'hFFFF);
		send_circle('{center_x: 14'h3FFF, center_y: 14'd0, circle_radius: 12'd80});
		send_circle('{center_x: 14'd0, center_y: 14'h3FFF, circle_radius: 12'd3840});
	endtask

	// Random bursts under one register setting.
	task automatic test_random_phase(input int count);
		int left;
		int burst;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 20);
			while (burst > 0 && left > 0) begin
				send_circle(random_circle());
				burst--;
				left--;
			end
			if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
		end
	endtask

	task automatic test_random_settings();
		write_register(REG_FOCAL_LENGTH, FOCAL_RST);
		write_register(REG_BALL_RADIUS, RADIUS_RST);
		write_register(REG_OPT_CENTER_X, 16'(OCX_RST));
		write_register(REG_OPT_CENTER_Y, 16'(OCY_RST));
		test_random_phase(200);
		for (int p = 0; p < 4; p++) begin
			write_register(REG_FOCAL_LENGTH, 16'($urandom_range(16, 65535)));
			write_register(REG_BALL_RADIUS, 16'($urandom_range(1, 65535)));
			write_register(REG_OPT_CENTER_X, 16'($urandom));
			write_register(REG_OPT_CENTER_Y, 16'($urandom));
			test_random_phase(80);
		end
	endtask

	// Long receiver hold-off while the sender keeps offering more circles than the
	// pipeline holds, so it fills up and stalls its input.
	task automatic test_backpressure();
		fork
			begin
				hold_off = 1;
				repeat (LATENCY + 200) @(posedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 300; i++) send_circle(random_circle());
		join
		quiet_rx = 1;
		test_random_phase(40);
		quiet_rx = 0;
		drain_results();
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = REG_FOCAL_LENGTH;
		cfg_data = '0;
		focal = FOCAL_RST;
		ball_r = RADIUS_RST;
		ocx = OCX_RST;
		ocy = OCY_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_register_extremes();
		test_random_settings();
		test_backpressure();
		drain_results();
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0) $display("tb_top passed");
		else $display("tb_top failed");
		$finish;
	end
endmodule

// File: files.f
sv/spfc_pkg.sv
sv/spfc_sqrt.sv
sv/spfc_div.sv
sv/sphere_position_from_circle_core.sv
tb/tb_top.sv
